[rtl/tdu_pkg.sv]
// ----------------------------------------------------------------------------
// tdu_pkg
// Shared widths, constants and the stage type for the tick-delta converter.
// ----------------------------------------------------------------------------
package tdu_pkg;

  localparam int CNT_W            = 64;
  localparam int FREQ_W           = 63;
  localparam int HALF_W           = CNT_W / 2;
  localparam int UNITS_PER_SECOND = 1000000;
  localparam int UNITS_W          = $clog2(UNITS_PER_SECOND + 1);
  localparam int PROD_W           = HALF_W + UNITS_W;
  localparam int NUM_W            = CNT_W + UNITS_W;
  localparam int DIV_STEPS        = CNT_W;

  localparam logic [UNITS_W-1:0] UNITS_C = UNITS_W'(UNITS_PER_SECOND);

  // One beat moving through the divider stages.
  typedef struct packed {
    logic              valid;
    logic              zero;   // frequency zero or end before start
    logic              sat;    // quotient does not fit in CNT_W bits
    logic [FREQ_W-1:0] rem;    // partial remainder
    logic [CNT_W-1:0]  nq;     // numerator bits shifting out, quotient bits in
  } div_stage_t;

endpackage

[rtl/tdu_in_if.sv]
// ----------------------------------------------------------------------------
// tdu_in_if
// Input channel: a pair of signed counter readings.
// ----------------------------------------------------------------------------
interface tdu_in_if import tdu_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] start_count;
  logic signed [CNT_W-1:0] end_count;

  modport source (output valid, output start_count, output end_count, input ready);
  modport sink   (input valid, input start_count, input end_count, output ready);

endinterface

[rtl/tdu_out_if.sv]
// ----------------------------------------------------------------------------
// tdu_out_if
// Result channel: elapsed microseconds.
// ----------------------------------------------------------------------------
interface tdu_out_if import tdu_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] elapsed_us;

  modport source (output valid, output elapsed_us, input ready);
  modport sink   (input valid, input elapsed_us, output ready);

endinterface

[rtl/tdu_front.sv]
// ----------------------------------------------------------------------------
// tdu_front
// Four-stage front end: difference, split multiply, numerator add, overflow
// check. Emits the first beat for the divider chain.
// ----------------------------------------------------------------------------
module tdu_front import tdu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [CNT_W-1:0] start_count,
  input  logic signed [CNT_W-1:0] end_count,
  input  logic [FREQ_W-1:0]       freq,
  output div_stage_t              stage_o
);

  logic [CNT_W:0]   diff;
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             z1_r, z2_r, z3_r;
  logic [CNT_W-1:0] delta_r;
  logic [PROD_W-1:0] lo_r, hi_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_nxt;
  div_stage_t       s4_r;
  div_stage_t       s4_nxt;

  // Sign-extended subtract gives both the difference and the signed compare.
  assign diff = {end_count[CNT_W-1], end_count} - {start_count[CNT_W-1], start_count};

  assign num_nxt = {hi_r, {HALF_W{1'b0}}} + NUM_W'(lo_r);

  always_comb begin
    s4_nxt.valid = v3_r;
    s4_nxt.zero  = z3_r;
    s4_nxt.sat   = !z3_r && (FREQ_W'(num_r[NUM_W-1:CNT_W]) >= freq);
    s4_nxt.rem   = FREQ_W'(num_r[NUM_W-1:CNT_W]);
    s4_nxt.nq    = num_r[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r    <= (freq == '0) || diff[CNT_W];
      delta_r <= diff[CNT_W-1:0];
      z2_r    <= z1_r;
      lo_r    <= PROD_W'(delta_r[HALF_W-1:0]) * PROD_W'(UNITS_C);
      hi_r    <= PROD_W'(delta_r[CNT_W-1:HALF_W]) * PROD_W'(UNITS_C);
      z3_r    <= z2_r;
      num_r   <= num_nxt;
      s4_r    <= s4_nxt;
    end
  end

  always_comb begin
    stage_o       = s4_r;
    stage_o.valid = v4_r;
  end

endmodule

[rtl/tdu_div_stage.sv]
// ----------------------------------------------------------------------------
// tdu_div_stage
// One restoring-division step: shift in a numerator bit, compare against the
// frequency, subtract, shift in a quotient bit.
// ----------------------------------------------------------------------------
module tdu_div_stage import tdu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [FREQ_W-1:0] freq,
  input  div_stage_t        stage_i,
  output div_stage_t        stage_o
);

  logic [CNT_W-1:0] trial;
  logic [CNT_W-1:0] diff;
  logic             ge;
  logic             valid_r;
  div_stage_t       data_r;
  div_stage_t       data_nxt;

  assign trial = {stage_i.rem, stage_i.nq[CNT_W-1]};
  assign diff  = trial - CNT_W'(freq);
  assign ge    = trial >= CNT_W'(freq);

  always_comb begin
    data_nxt       = stage_i;
    data_nxt.rem   = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    data_nxt.nq    = {stage_i.nq[CNT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    stage_o       = data_r;
    stage_o.valid = valid_r;
  end

endmodule

[rtl/tdu_skid.sv]
// ----------------------------------------------------------------------------
// tdu_skid
// Two-entry output buffer. Space is a registered flag, so the pipeline
// enable never depends on the downstream ready in the same cycle.
// ----------------------------------------------------------------------------
module tdu_skid import tdu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [CNT_W-1:0] push_data,
  output logic             space,
  tdu_out_if.source        out_ch
);

  logic             main_valid_r, spare_valid_r;
  logic [CNT_W-1:0] main_r, spare_r;
  logic             pop;

  assign pop   = main_valid_r && out_ch.ready;
  assign space = !spare_valid_r;

  assign out_ch.valid      = main_valid_r;
  assign out_ch.elapsed_us = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (spare_valid_r) begin
          spare_valid_r <= 1'b0;
        end else begin
          main_valid_r <= push;
        end
      end else if (!main_valid_r) begin
        main_valid_r <= push;
      end else if (push) begin
        spare_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= spare_valid_r ? spare_r : push_data;
    end else if (!main_valid_r) begin
      main_r <= push_data;
    end else if (push) begin
      spare_r <= push_data;
    end
  end

  a_spare_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    spare_valid_r |-> main_valid_r)
    else $error("spare entry held while main entry empty");

  a_stall_fills_spare: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && main_valid_r |=> spare_valid_r)
    else $error("beat pushed into full main entry was dropped");

  a_spare_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    pop && spare_valid_r |=> main_valid_r && main_r == $past(spare_r))
    else $error("spare entry not promoted on pop");

endmodule

[rtl/tick_delta_to_microseconds.sv]
// ----------------------------------------------------------------------------
// tick_delta_to_microseconds
// Converts the span between two signed counter readings into elapsed
// microseconds, floor(delta * 1e6 / freq), saturated to all ones.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid / ready    start_count, end_count (64b signed)
//   out_ch   source     valid / ready    elapsed_us (64b unsigned)
//   cfg      write      cfg_we           cfg_wdata: tick_frequency (63b)
//
// One beat per cycle while the output buffer has space; a beat passes 4 front
// stages, 64 restoring divider stages (one bit each) and one output register.
// Reset clears all valid bits and tick_frequency; in_ch.ready is high from
// the cycle after reset. A stalled output fills the two-entry output buffer,
// then the whole pipeline holds until it drains; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tick_delta_to_microseconds import tdu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [FREQ_W-1:0] cfg_wdata,
  tdu_in_if.sink            in_ch,
  tdu_out_if.source         out_ch
);

  logic [FREQ_W-1:0] freq_r;
  logic              en;
  logic              push;
  logic [CNT_W-1:0]  result;
  div_stage_t        stg [0:DIV_STEPS];
  div_stage_t        last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
    end else if (cfg_we) begin
      freq_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = en;

  tdu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .start_count (in_ch.start_count),
    .end_count   (in_ch.end_count),
    .freq        (freq_r),
    .stage_o     (stg[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    tdu_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .freq    (freq_r),
      .stage_i (stg[i]),
      .stage_o (stg[i+1])
    );
  end

  assign last = stg[DIV_STEPS];
  assign push = en && last.valid;

  always_comb begin
    if (last.zero) begin
      result = '0;
    end else if (last.sat) begin
      result = '1;
    end else begin
      result = last.nq;
    end
  end

  tdu_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .space     (en),
    .out_ch    (out_ch)
  );

endmodule

[dv/tb_tick_delta_to_microseconds.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tick_delta_to_microseconds
// Self-checking bench for the tick-delta converter. Directed pairs cover the
// counter extremes, a zero frequency, end-before-start and both saturation
// paths. Random pairs follow over several frequencies, with random stalls on
// either side. Each result is compared in order against a 128-bit
// floor(delta * 1e6 / freq) prediction.
// ----------------------------------------------------------------------------
module tb_tick_delta_to_microseconds;
  import tdu_pkg::*;

  localparam logic [CNT_W-1:0]  CNT_MIN  = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  // largest whole-second count whose scaled value still fits in 64 bits
  localparam logic [CNT_W-1:0]  WHOLE_LIMIT = 64'd18446744073709;
  localparam int                ITEMS_PER_PHASE = 128;
  localparam int                NUM_PHASES = 9;

  typedef struct {
    logic [CNT_W-1:0] start_count;
    logic [CNT_W-1:0] end_count;
    logic [CNT_W-1:0] elapsed_us;
  } elapsed_entry_t;

  class elapsed_scoreboard;
    logic [FREQ_W-1:0] tick_freq;
    elapsed_entry_t    expected_q[$];
    int                errors;

    function new();
      tick_freq = '0;
      errors    = 0;
    endfunction

    function void set_frequency(logic [FREQ_W-1:0] f);
      tick_freq = f;
    endfunction

    // Exact floor(delta * units / freq) in 128 bits, then saturate.
    function logic [CNT_W-1:0] predict_elapsed(logic [CNT_W-1:0] s, logic [CNT_W-1:0] e);
      logic [CNT_W-1:0] delta;
      logic [127:0]     num;
      logic [127:0]     quo;
      if (tick_freq == '0 || $signed(e) < $signed(s)) return '0;
      delta = e - s;
      num = {64'd0, delta} * 128'(UNITS_PER_SECOND);
      quo = num / {65'd0, tick_freq};
      if (quo[127:64] != '0) return '1;
      return quo[63:0];
    endfunction

    function void note_input(logic [CNT_W-1:0] s, logic [CNT_W-1:0] e);
      elapsed_entry_t ent;
      ent.start_count = s;
      ent.end_count   = e;
      ent.elapsed_us  = predict_elapsed(s, e);
      expected_q.push_back(ent);
    endfunction

    function void check_result(logic [CNT_W-1:0] got);
      elapsed_entry_t ent;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected elapsed_us beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      ent = expected_q.pop_front();
      if (got !== ent.elapsed_us) begin
        $display("%0t: elapsed_us mismatch (start %h end %h freq %h): expected %h actual %h",
                 $time, ent.start_count, ent.end_count, tick_freq, ent.elapsed_us, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [FREQ_W-1:0] cfg_wdata;
  int                tx_idle_pct;
  int                rx_idle_pct;

  tdu_in_if  in_ch_if ();
  tdu_out_if out_ch_if ();

  elapsed_scoreboard sb = new();

  tick_delta_to_microseconds DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch_if),
    .out_ch    (out_ch_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_tick_delta_to_microseconds failed");
    $finish;
  end

  // Result side: random stall at the falling edge.
  initial begin
    out_ch_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch_if.valid && out_ch_if.ready) begin
      sb.check_result(out_ch_if.elapsed_us);
    end
  end

  function automatic logic [CNT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic set_idling(input int stage);
    case (stage)
      0: begin
        tx_idle_pct = 34;
        rx_idle_pct = 87;
      end
      1: begin
        tx_idle_pct = 87;
        rx_idle_pct = 34;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  // Hold valid across back-to-back beats; drop it only for an idle cycle.
  task automatic send_item(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] e);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch_if.valid = 1'b0;
      @(negedge clk);
    end
    in_ch_if.valid       = 1'b1;
    in_ch_if.start_count = s;
    in_ch_if.end_count   = e;
    do @(posedge clk); while (!in_ch_if.ready);
    sb.note_input(s, e);
    @(negedge clk);
  endtask

  task automatic write_frequency(input logic [FREQ_W-1:0] f);
    in_ch_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_wdata = f;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_frequency(f);
  endtask

  task automatic send_random_item(input logic [FREQ_W-1:0] f);
    int               kind;
    logic [CNT_W-1:0] delta;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] e;
    logic [CNT_W-1:0] fw;
    logic [127:0]     lim;
    kind = $urandom_range(0, 99);
    fw   = {1'b0, f};
    if (kind < 10) begin
      s = rand64();
      e = rand64();
    end else begin
      if (kind < 30 && f != '0) begin
        delta = rand64() % fw;
      end else if (kind < 45 && f != '0) begin
        // land near the saturation threshold from either side
        lim = {64'd0, fw} * {64'd0, WHOLE_LIMIT} + {64'd0, rand64() % fw};
        delta = (lim[127:64] != '0) ? rand64() : lim[63:0];
      end else if (kind < 55 && f != '0) begin
        delta = fw * 64'($urandom_range(0, 1000));
      end else begin
        delta = rand64() >> $urandom_range(0, 63);
      end
      // place the span so that end = start + delta has no signed wrap
      offset = rand64();
      if (delta != '0) offset = offset % (~delta + 64'd1);
      s = offset ^ CNT_MIN;
      e = s + delta;
      if (kind >= 90) begin
        offset = s;
        s      = e;
        e      = offset;
      end
    end
    send_item(s, e);
  endtask

  initial begin
    logic [FREQ_W-1:0] phase_freq [NUM_PHASES];
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch_if.valid       = 1'b0;
    in_ch_if.start_count = '0;
    in_ch_if.end_count   = '0;
    set_idling(0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero frequency
    write_frequency('0);
    send_item(64'd0, 64'd100);
    send_item(CNT_MIN, CNT_MAX);

    // one tick per second: first saturation path
    write_frequency(63'd1);
    send_item(64'd0, 64'd0);
    send_item(64'd5, 64'd3);
    send_item(CNT_MIN, CNT_MAX);
    send_item(64'd0, WHOLE_LIMIT);
    send_item(64'd0, WHOLE_LIMIT + 64'd1);
    send_item(-64'sd1, 64'd0);
    send_item(CNT_MAX, CNT_MIN);
    send_item(CNT_MIN, CNT_MIN);

    // fractional part and saturation from the sum
    write_frequency(63'd3);
    send_item(64'd0, 64'd1);
    send_item(64'd0, 64'd2);
    send_item(64'd0, WHOLE_LIMIT * 64'd3 + 64'd1);
    send_item(64'd0, WHOLE_LIMIT * 64'd3 + 64'd2);
    send_item(-64'sd7, -64'sd4);

    write_frequency(FREQ_MAX);
    send_item(CNT_MIN, CNT_MAX);
    send_item(64'd0, {1'b0, FREQ_MAX} - 64'd1);
    send_item(64'd0, 64'd1);
    send_item(CNT_MIN, -64'sd1);

    phase_freq[0] = 63'd1;
    phase_freq[1] = FREQ_MAX;
    phase_freq[2] = 63'd1_000_000;
    phase_freq[3] = 63'd3;
    phase_freq[4] = 63'd32_768;
    phase_freq[5] = 63'($urandom_range(1, 1 << 20));
    phase_freq[6] = 63'({$urandom, $urandom});
    phase_freq[7] = 63'd19_200_000;
    phase_freq[8] = '0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_frequency(phase_freq[p]);
      set_idling(p / 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_item(phase_freq[p]);
      end
    end

    in_ch_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // catch any stray beat
    repeat (80) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_tick_delta_to_microseconds passed");
    end else begin
      $display("tb_tick_delta_to_microseconds failed");
    end
    $finish;
  end

endmodule
